[rtl/gtl_pkg.sv]
// gtl_pkg: shared types and constants for the glyph text layout unit
// no dependencies
package gtl_pkg;

  localparam logic [2:0] FUNC_LOAD_GLYPH = 3'd0;
  localparam logic [2:0] FUNC_LOAD_KERN  = 3'd1;
  localparam logic [2:0] FUNC_SET_ORIGIN = 3'd2;
  localparam logic [2:0] FUNC_CUR_BASE   = 3'd3;
  localparam logic [2:0] FUNC_CUR_TOP    = 3'd4;
  localparam logic [2:0] FUNC_CHAR       = 3'd5;
  localparam logic [2:0] FUNC_CLEAR      = 3'd6;

  localparam logic [1:0] REG_TAB_SIZE    = 2'd0;
  localparam logic [1:0] REG_LINE_HEIGHT = 2'd1;
  localparam logic [1:0] REG_BASELINE    = 2'd2;
  localparam logic [1:0] REG_DRAW_COLOR  = 2'd3;

  localparam logic [20:0] CODE_NEWLINE = 21'd10;
  localparam logic [20:0] CODE_TAB     = 21'd9;

  typedef struct packed {
    logic [2:0]         func;
    logic [20:0]        code;
    logic [20:0]        next_code;
    logic [15:0]        tex_x;
    logic [15:0]        tex_y;
    logic [15:0]        glyph_width;
    logic [15:0]        glyph_height;
    logic signed [15:0] x_offset;
    logic signed [15:0] y_offset;
    logic signed [15:0] advance;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
  } item_t;

  typedef struct packed {
    logic [15:0]        tex_u;
    logic [15:0]        tex_v;
    logic signed [15:0] vert_x;
    logic signed [15:0] vert_y;
    logic [31:0]        vert_color;
    logic               last;
  } result_t;

  typedef struct packed {
    logic [20:0] key;
    logic [15:0] u0;
    logic [15:0] v0;
    logic [15:0] u1;
    logic [15:0] v1;
    logic [15:0] gx;
    logic [15:0] gy;
    logic [15:0] adv;
  } glyph_rec_t;

  typedef struct packed {
    logic [41:0] key;
    logic [15:0] amount;
  } kern_rec_t;

endpackage

[rtl/gtl_ram.sv]
// gtl_ram: single-port-write, single-port-read synchronous memory
// registered read data, no dependencies
module gtl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[rtl/gtl_tab_div.sv]
// gtl_tab_div: serial signed-by-unsigned divide for tab stops, then (q+1)*t
// uses no package
module gtl_tab_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] x,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [31:0] result
);

  localparam logic [1:0] P_IDLE = 2'd0;
  localparam logic [1:0] P_RUN  = 2'd1;
  localparam logic [1:0] P_FIX  = 2'd2;
  localparam logic [1:0] P_MUL  = 2'd3;

  logic [1:0]  phase;
  logic [4:0]  count;
  logic        neg;
  logic [15:0] div;
  logic [15:0] rem;
  logic [31:0] quo;
  logic [31:0] qp1;
  logic [16:0] rem_sh;
  logic [16:0] rem_sub;
  logic [47:0] prod;

  assign rem_sh  = {rem, quo[31]};
  assign rem_sub = rem_sh - {1'b0, div};
  assign prod    = qp1 * div;

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      phase <= P_IDLE;
    end else begin
      unique case (phase)
        P_IDLE: begin
          if (start) begin
            neg   <= x[31];
            quo   <= x[31] ? -x : x;
            div   <= divisor;
            rem   <= '0;
            count <= '0;
            phase <= P_RUN;
          end
        end
        P_RUN: begin
          if (rem_sh >= {1'b0, div}) begin
            rem <= rem_sub[15:0];
            quo <= {quo[30:0], 1'b1};
          end else begin
            rem <= rem_sh[15:0];
            quo <= {quo[30:0], 1'b0};
          end
          count <= count + 5'd1;
          if (count == 5'd31) begin
            phase <= P_FIX;
          end
        end
        P_FIX: begin
          qp1   <= (neg ? -quo : quo) + 32'd1;
          phase <= P_MUL;
        end
        P_MUL: begin
          result <= prod[31:0];
          done   <= 1'b1;
          phase  <= P_IDLE;
        end
        default: phase <= P_IDLE;
      endcase
    end
  end

endmodule

[rtl/glyph_text_layout_unit.sv]
// glyph_text_layout_unit: top level, sequencer over glyph and kerning memories
// uses gtl_pkg, gtl_ram, gtl_tab_div
// control items and newlines finish in the idle state; a char runs a binary search over the glyph table
// and, if the glyph is found, over the kerning table, each probe a memory read state and a compare state;
// a tab waits on the serial divider; a found glyph gives two result transactions on consecutive cycles
// one transaction at a time, busy high until done; results cannot be stalled
// synchronous reset empties both tables, homes cursor and origin, loads register defaults
module glyph_text_layout_unit #(
  parameter int MAX_GLYPHS     = 256,
  parameter int MAX_KERN_PAIRS = 1024
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  gtl_pkg::item_t  item,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_index,
  input  logic [31:0]     cfg_data,
  output logic            result_valid,
  output gtl_pkg::result_t result
);
  import gtl_pkg::*;

  localparam int GAW = (MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1;
  localparam int KAW = (MAX_KERN_PAIRS > 1) ? $clog2(MAX_KERN_PAIRS) : 1;
  localparam int GCW = $clog2(MAX_GLYPHS + 1);
  localparam int KCW = $clog2(MAX_KERN_PAIRS + 1);
  localparam int SW  = (GCW > KCW) ? GCW : KCW;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_GRD  = 4'd1;
  localparam logic [3:0] S_GCMP = 4'd2;
  localparam logic [3:0] S_KRD  = 4'd3;
  localparam logic [3:0] S_KCMP = 4'd4;
  localparam logic [3:0] S_GEOM = 4'd5;
  localparam logic [3:0] S_EMIT = 4'd6;
  localparam logic [3:0] S_TAB  = 4'd7;

  logic [3:0]  state;
  logic [15:0] tab_size;
  logic [15:0] line_height;
  logic [15:0] baseline_offset;
  logic [31:0] draw_color;
  logic [GCW-1:0] glyph_count;
  logic [KCW-1:0] kern_count;
  logic [20:0] last_gkey;
  logic [41:0] last_kkey;
  logic [31:0] cursor_x, cursor_y, origin_x, origin_y;
  logic [20:0] code_r, next_r;
  logic [SW-1:0] lo, hi, mid, mid_c;
  glyph_rec_t g_rec;
  logic [15:0] k_amt;
  logic [15:0] vx0, vy0;

  logic        accept;
  logic        g_we, k_we;
  glyph_rec_t  g_wdata, g_rdata;
  kern_rec_t   k_wdata, k_rdata;
  logic        div_start, div_done;
  logic [31:0] div_result;
  logic [15:0] div_t;

  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);
  assign mid_c  = lo + ((hi - lo) >> 1);

  assign g_we = accept && item.func == FUNC_LOAD_GLYPH &&
                glyph_count < GCW'(MAX_GLYPHS) &&
                (glyph_count == '0 || item.code > last_gkey);
  assign k_we = accept && item.func == FUNC_LOAD_KERN &&
                kern_count < KCW'(MAX_KERN_PAIRS) &&
                (kern_count == '0 || {item.code, item.next_code} > last_kkey);

  always_comb begin
    g_wdata.key = item.code;
    g_wdata.u0  = item.tex_x;
    g_wdata.v0  = item.tex_y;
    g_wdata.u1  = item.tex_x + item.glyph_width;
    g_wdata.v1  = item.tex_y + item.glyph_height;
    g_wdata.gx  = item.x_offset;
    g_wdata.gy  = item.y_offset - baseline_offset;
    g_wdata.adv = item.advance;
    k_wdata.key    = {item.code, item.next_code};
    k_wdata.amount = item.advance;
  end

  gtl_ram #(.WIDTH($bits(glyph_rec_t)), .DEPTH(MAX_GLYPHS), .AW(GAW)) u_glyph_ram (
    .clk   (clk),
    .we    (g_we),
    .waddr (glyph_count[GAW-1:0]),
    .wdata (g_wdata),
    .raddr (mid_c[GAW-1:0]),
    .rdata (g_rdata)
  );

  gtl_ram #(.WIDTH($bits(kern_rec_t)), .DEPTH(MAX_KERN_PAIRS), .AW(KAW)) u_kern_ram (
    .clk   (clk),
    .we    (k_we),
    .waddr (kern_count[KAW-1:0]),
    .wdata (k_wdata),
    .raddr (mid_c[KAW-1:0]),
    .rdata (k_rdata)
  );

  assign div_t     = (tab_size == 16'd0) ? 16'd1 : tab_size;
  assign div_start = accept && item.func == FUNC_CHAR && item.code == CODE_TAB;

  gtl_tab_div u_tab_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .x       (cursor_x),
    .divisor (div_t),
    .done    (div_done),
    .result  (div_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      tab_size        <= 16'd100;
      line_height     <= '0;
      baseline_offset <= '0;
      draw_color      <= 32'hFFFF_FFFF;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TAB_SIZE:    tab_size        <= cfg_data[15:0];
        REG_LINE_HEIGHT: line_height     <= cfg_data[15:0];
        REG_BASELINE:    baseline_offset <= cfg_data[15:0];
        REG_DRAW_COLOR:  draw_color      <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    result_valid <= 1'b0;
    if (rst) begin
      state       <= S_IDLE;
      glyph_count <= '0;
      kern_count  <= '0;
      cursor_x    <= '0;
      cursor_y    <= '0;
      origin_x    <= '0;
      origin_y    <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (g_we) begin
            glyph_count <= glyph_count + 1'b1;
            last_gkey   <= item.code;
          end
          if (k_we) begin
            kern_count <= kern_count + 1'b1;
            last_kkey  <= {item.code, item.next_code};
          end
          if (accept) begin
            code_r <= item.code;
            next_r <= item.next_code;
            unique case (item.func)
              FUNC_SET_ORIGIN: begin
                origin_x <= item.pos_x;
                origin_y <= item.pos_y;
                cursor_x <= item.pos_x;
                cursor_y <= item.pos_y;
              end
              FUNC_CUR_BASE: begin
                cursor_x <= origin_x + item.pos_x;
                cursor_y <= origin_y + item.pos_y;
              end
              FUNC_CUR_TOP: begin
                cursor_x <= origin_x + item.pos_x;
                cursor_y <= origin_y + item.pos_y
                            - ({16'd0, line_height} - {16'd0, baseline_offset});
              end
              FUNC_CLEAR: begin
                glyph_count <= '0;
                kern_count  <= '0;
              end
              FUNC_CHAR: begin
                if (item.code == CODE_NEWLINE) begin
                  cursor_x <= origin_x;
                  cursor_y <= cursor_y + {16'd0, line_height};
                end else if (item.code == CODE_TAB) begin
                  state <= S_TAB;
                end else begin
                  lo    <= '0;
                  hi    <= SW'(glyph_count);
                  state <= S_GRD;
                end
              end
              default: ;
            endcase
          end
        end
        S_GRD: begin
          mid <= mid_c;
          state <= (lo < hi) ? S_GCMP : S_IDLE;
        end
        S_GCMP: begin
          if (g_rdata.key == code_r) begin
            g_rec <= g_rdata;
            lo    <= '0;
            hi    <= SW'(kern_count);
            state <= S_KRD;
          end else begin
            if (g_rdata.key < code_r) lo <= mid + 1'b1;
            else hi <= mid;
            state <= S_GRD;
          end
        end
        S_KRD: begin
          mid <= mid_c;
          if (lo < hi) begin
            state <= S_KCMP;
          end else begin
            k_amt <= '0;
            state <= S_GEOM;
          end
        end
        S_KCMP: begin
          if (k_rdata.key == {code_r, next_r}) begin
            k_amt <= k_rdata.amount;
            state <= S_GEOM;
          end else begin
            if (k_rdata.key < {code_r, next_r}) lo <= mid + 1'b1;
            else hi <= mid;
            state <= S_KRD;
          end
        end
        S_GEOM: begin
          vx0                <= cursor_x[15:0] + g_rec.gx;
          vy0                <= cursor_y[15:0] + g_rec.gy;
          result.tex_u       <= g_rec.u0;
          result.tex_v       <= g_rec.v0;
          result.vert_x      <= cursor_x[15:0] + g_rec.gx;
          result.vert_y      <= cursor_y[15:0] + g_rec.gy;
          result.vert_color  <= draw_color;
          result.last        <= 1'b0;
          result_valid       <= 1'b1;
          state              <= S_EMIT;
        end
        S_EMIT: begin
          result.tex_u  <= g_rec.u1;
          result.tex_v  <= g_rec.v1;
          result.vert_x <= vx0 + (g_rec.u1 - g_rec.u0);
          result.vert_y <= vy0 + (g_rec.v1 - g_rec.v0);
          result.last   <= 1'b1;
          result_valid  <= 1'b1;
          cursor_x <= cursor_x + {16'd0, g_rec.adv} + {{16{k_amt[15]}}, k_amt};
          state    <= S_IDLE;
        end
        S_TAB: begin
          if (div_done) begin
            cursor_x <= div_result;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_pair: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.last |=> result_valid && result.last)
    else $error("first corner not followed by second");
  a_gcount: assert property (@(posedge clk) disable iff (rst)
    glyph_count <= GCW'(MAX_GLYPHS))
    else $error("glyph count overflow");
  a_kcount: assert property (@(posedge clk) disable iff (rst)
    kern_count <= KCW'(MAX_KERN_PAIRS))
    else $error("kerning count overflow");
  a_emit_src: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.last |-> $past(state) == S_GEOM)
    else $error("first corner without a found glyph");

endmodule
